/* hdl/udpc_pkg.sv */
package udpc_pkg;

  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 32;
  localparam int HdrBytes  = 8;
  localparam int HdrIdxW   = $clog2(HdrBytes);

  localparam logic [CfgIdxW-1:0] RegSourceAddress = 8'd0;
  localparam logic [CfgIdxW-1:0] RegDestAddress   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegSourcePort    = 8'd2;
  localparam logic [CfgIdxW-1:0] RegDestPort      = 8'd3;

  localparam logic [15:0] UdpProtocol = 16'd17;
  localparam logic [15:0] MaxPayload  = 16'd65527;
  localparam logic [15:0] CountSat    = 16'hffff;
  localparam logic [15:0] UdpHdrLen   = 16'd8;
  localparam logic [15:0] AllOnes16   = 16'hffff;
  localparam logic [HdrIdxW-1:0] LastHdrIdx = 3'(HdrBytes - 1);

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_present;
    logic       end_of_payload;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         header_byte;
    logic [HdrIdxW-1:0] header_index;
    logic               header_last;
    logic               oversize;
  } out_item_t;

  // datagram totals handed to the header serializer
  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] length;
    logic        oversize;
  } dgram_t;

  // 16-bit ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

/* hdl/udp_header_checksum_builder_core.sv */
// Channel  Ports                                  Dir  Payload
// -------  -------------------------------------  ---  ---------------------------------
// in       in_valid, in_stall, in_data            in   in_item_t: byte, present, end
// out      out_valid, out_stall, out_data         out  out_item_t: byte, index, last, ovf
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  in  register index, 32-bit value
//
// One input item per cycle while in_stall is low; payload bytes never stall on their own.
// An end item yields eight header transfers, one per cycle while out_stall is low.
// The header register holds one run; a second end item waits behind it (input stalls
// while the run still has bytes out, the staged totals are full and an end item is held).
// Synchronous active-low reset clears all datagram state and the config registers.
// Output stall holds the current header byte; cfg_ready is always high.
module udp_header_checksum_builder_core
  import udpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [31:0] src_addr_r, dst_addr_r;
  logic [15:0] src_port_r, dst_port_r;
  logic [15:0] cfg_sum_r, cfg_sum_nxt;

  in_item_t    s0_r;
  logic        s0_valid_r, s0_valid_nxt;
  logic        s0_adv, s0_fire, in_fire;

  dgram_t      s1_r, s1_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_ld, ld_ready;

  logic [15:0] sum_r, sum_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        odd_r, odd_nxt;
  logic        ovf_r, ovf_nxt;
  logic [15:0] final_sum;

  logic [18:0] cfg_total;
  logic [16:0] cfg_fold;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r <= '0;
      dst_addr_r <= '0;
      src_port_r <= '0;
      dst_port_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegSourceAddress: src_addr_r <= cfg_data;
        RegDestAddress:   dst_addr_r <= cfg_data;
        RegSourcePort:    src_port_r <= cfg_data[15:0];
        RegDestPort:      dst_port_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pseudo-header and port terms; the user keeps them constant while a datagram is in flight (not enforced)
  always_comb begin
    cfg_total = {3'b0, src_addr_r[31:16]} + {3'b0, src_addr_r[15:0]}
              + {3'b0, dst_addr_r[31:16]} + {3'b0, dst_addr_r[15:0]}
              + {3'b0, UdpProtocol} + {3'b0, src_port_r} + {3'b0, dst_port_r};
    cfg_fold    = {1'b0, cfg_total[15:0]} + {14'd0, cfg_total[18:16]};
    cfg_sum_nxt = cfg_fold[15:0] + {15'd0, cfg_fold[16]};
  end

  always_ff @(posedge clk) begin
    cfg_sum_r <= cfg_sum_nxt;
  end

  // input register
  assign s1_ld    = s1_valid_r && ld_ready;
  assign s0_adv   = !s0_r.end_of_payload || !s1_valid_r || s1_ld;
  assign s0_fire  = s0_valid_r && s0_adv;
  assign in_stall = s0_valid_r && !s0_adv;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_fire) begin
      s0_valid_nxt = 1'b1;
    end else if (s0_fire) begin
      s0_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_r <= in_data;
    end
  end

  // running sum over byte pairs
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    held_nxt  = held_r;
    odd_nxt   = odd_r;
    ovf_nxt   = ovf_r;
    if (s0_r.byte_present) begin
      if (odd_r) begin
        sum_nxt = oc_add(sum_r, {held_r, s0_r.payload_byte});
        odd_nxt = 1'b0;
      end else begin
        held_nxt = s0_r.payload_byte;
        odd_nxt  = 1'b1;
      end
      if (count_r >= MaxPayload) begin
        ovf_nxt = 1'b1;
      end
      if (count_r != CountSat) begin
        count_nxt = count_r + 16'd1;
      end
    end
    // odd length: pad the held byte with a zero low byte
    final_sum = odd_nxt ? oc_add(sum_nxt, {held_nxt, 8'd0}) : sum_nxt;
    s1_nxt.sum      = final_sum;
    s1_nxt.length   = count_nxt + UdpHdrLen;
    s1_nxt.oversize = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      held_r  <= '0;
      odd_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (s0_fire) begin
      if (s0_r.end_of_payload) begin
        sum_r   <= '0;
        count_r <= '0;
        held_r  <= '0;
        odd_r   <= 1'b0;
        ovf_r   <= 1'b0;
      end else begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        held_r  <= held_nxt;
        odd_r   <= odd_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  // staged datagram totals
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s0_fire && s0_r.end_of_payload) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ld) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && s0_r.end_of_payload) begin
      s1_r <= s1_nxt;
    end
  end

  udpc_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .source_port (src_port_r),
    .dest_port   (dst_port_r),
    .cfg_sum     (cfg_sum_r),
    .ld_valid    (s1_valid_r),
    .ld_data     (s1_r),
    .ld_ready    (ld_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire && s0_r.end_of_payload |=> sum_r == 16'd0 && count_r == 16'd0 && !odd_r && !ovf_r)
    else $error("datagram state not cleared after end item");

  a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r > MaxPayload)
    else $error("oversize flag set with a legal byte count");

  a_stall_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s0_valid_r && s0_r.end_of_payload && s1_valid_r)
    else $error("input stalled without a blocked end item");

endmodule

/* hdl/udpc_emit.sv */
module udpc_emit
  import udpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [15:0] cfg_sum,
  input  logic        ld_valid,
  input  dgram_t      ld_data,
  output logic        ld_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [7:0]         hdr_r [HdrBytes];
  logic [7:0]         hdr_nxt [HdrBytes];
  logic [HdrIdxW-1:0] idx_r, idx_nxt;
  logic               busy_r, busy_nxt;
  logic               ovf_r;
  logic               load;
  logic               last_xfer;
  logic [17:0]        total;
  logic [16:0]        fold1;
  logic [15:0]        fold2;
  logic [15:0]        cks;

  // finish the checksum: partial sum, config terms, length twice (pseudo + header)
  always_comb begin
    total = {2'b0, ld_data.sum} + {2'b0, cfg_sum}
          + {2'b0, ld_data.length} + {2'b0, ld_data.length};
    fold1 = {1'b0, total[15:0]} + {15'd0, total[17:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    cks   = ~fold2;
    if (cks == 16'd0) begin
      cks = AllOnes16;
    end
    hdr_nxt[0] = source_port[15:8];
    hdr_nxt[1] = source_port[7:0];
    hdr_nxt[2] = dest_port[15:8];
    hdr_nxt[3] = dest_port[7:0];
    hdr_nxt[4] = ld_data.length[15:8];
    hdr_nxt[5] = ld_data.length[7:0];
    hdr_nxt[6] = cks[15:8];
    hdr_nxt[7] = cks[7:0];
  end

  assign last_xfer = busy_r && !out_stall && (idx_r == LastHdrIdx);
  assign ld_ready  = !busy_r || last_xfer;
  assign load      = ld_valid && ld_ready;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (last_xfer) begin
      busy_nxt = 1'b0;
    end else if (busy_r && !out_stall) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hdr_r <= hdr_nxt;
      ovf_r <= ld_data.oversize;
    end
  end

  assign out_valid             = busy_r;
  assign out_data.header_byte  = hdr_r[idx_r];
  assign out_data.header_index = idx_r;
  assign out_data.header_last  = (idx_r == LastHdrIdx);
  assign out_data.oversize     = ovf_r;

  a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_stall && idx_r != LastHdrIdx |=> busy_r && idx_r == $past(idx_r) + 1'b1)
    else $error("header index did not advance after a transfer");

  a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy_r || last_xfer)
    else $error("header reloaded before the run finished");

endmodule

/* dv/udp_header_checksum_builder_core_tb.sv */
module udp_header_checksum_builder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import udpc_pkg::*;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } stim_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  udp_header_checksum_builder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // pending input items and expected header bytes
  stim_t     byte_q[$];
  out_item_t header_q[$];
  int        errors = 0;

  int unsigned in_gap_max = 0;
  int unsigned out_gap_max = 0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  logic        long_hold = 1'b0;

  // shadow of the block's registers and datagram state
  logic [31:0] reg_src_addr, reg_dst_addr;
  logic [15:0] reg_src_port, reg_dst_port;
  logic [15:0] csum_acc;
  logic [15:0] byte_cnt;
  logic [7:0]  hi_byte;
  logic        odd_byte;
  logic        ovf_flag;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    int unsigned t;
    t = 32'(a) + 32'(b);
    return 16'(t + (t >> 16));
  endfunction

  // pseudo-header plus UDP header words, length counted twice
  function automatic logic [15:0] header_sum(input logic [31:0] sa, input logic [31:0] da,
                                             input logic [15:0] sp, input logic [15:0] dp,
                                             input logic [15:0] len);
    logic [15:0] s;
    s = ones_add(sa[31:16], sa[15:0]);
    s = ones_add(s, da[31:16]);
    s = ones_add(s, da[15:0]);
    s = ones_add(s, UdpProtocol);
    s = ones_add(s, len);
    s = ones_add(s, sp);
    s = ones_add(s, dp);
    return ones_add(s, len);
  endfunction

  task automatic predict_header(input in_item_t it);
    logic [15:0] s, len, cks;
    logic [63:0] hdr;
    out_item_t   o;
    if (it.byte_present) begin
      if (odd_byte) begin
        csum_acc = ones_add(csum_acc, {hi_byte, it.payload_byte});
        odd_byte = 1'b0;
      end else begin
        hi_byte  = it.payload_byte;
        odd_byte = 1'b1;
      end
      if (byte_cnt >= MaxPayload) ovf_flag = 1'b1;
      if (byte_cnt != CountSat) byte_cnt = byte_cnt + 16'd1;
    end
    if (it.end_of_payload) begin
      len = byte_cnt + UdpHdrLen;
      s = csum_acc;
      if (odd_byte) s = ones_add(s, {hi_byte, 8'h00});
      s = ones_add(s, header_sum(reg_src_addr, reg_dst_addr, reg_src_port, reg_dst_port, len));
      cks = ~s;
      if (cks == 16'h0000) cks = AllOnes16;
      hdr = {reg_src_port, reg_dst_port, len, cks};
      for (int k = 0; k < HdrBytes; k++) begin
        o.header_byte  = hdr[63 - 8 * k -: 8];
        o.header_index = HdrIdxW'(k);
        o.header_last  = (o.header_index == LastHdrIdx);
        o.oversize     = ovf_flag;
        header_q.push_back(o);
      end
      csum_acc = '0;
      byte_cnt = '0;
      hi_byte  = '0;
      odd_byte = 1'b0;
      ovf_flag = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // driver: one item per slot, gap drawn per item, payload held while stalled
  always @(posedge clk) begin
    stim_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait  <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_wait != 0) begin
        in_valid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (byte_q.size() != 0) begin
        s = byte_q.pop_front();
        in_valid <= 1'b1;
        in_data  <= s.item;
        in_wait  <= s.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall after each header transfer, plus the long hold-off
  always @(posedge clk) begin
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait  <= 0;
    end else begin
      n = out_wait;
      if (out_valid && !out_stall) n = $urandom_range(out_gap_max);
      if (long_hold) begin
        out_stall <= 1'b1;
        out_wait  <= n;
      end else if (n != 0) begin
        out_stall <= 1'b1;
        out_wait  <= n - 1;
      end else begin
        out_stall <= 1'b0;
        out_wait  <= 0;
      end
    end
  end

  // monitor: register writes, accepted items and header transfers
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      reg_src_addr = '0;
      reg_dst_addr = '0;
      reg_src_port = '0;
      reg_dst_port = '0;
      csum_acc = '0;
      byte_cnt = '0;
      hi_byte  = '0;
      odd_byte = 1'b0;
      ovf_flag = 1'b0;
      header_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegSourceAddress: reg_src_addr = cfg_data;
          RegDestAddress:   reg_dst_addr = cfg_data;
          RegSourcePort:    reg_src_port = cfg_data[15:0];
          RegDestPort:      reg_dst_port = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (header_q.size() == 0) begin
          $error("header transfer with nothing expected: %p", out_data);
          errors++;
        end else begin
          want = header_q.pop_front();
          check_field("header_byte", want.header_byte, out_data.header_byte);
          check_field("header_index", 8'(want.header_index), 8'(out_data.header_index));
          check_field("header_last", 8'(want.header_last), 8'(out_data.header_last));
          check_field("oversize", 8'(want.oversize), 8'(out_data.oversize));
        end
      end
      if (in_valid && !in_stall) predict_header(in_data);
    end
  end

  task automatic offer(input logic [7:0] b, input logic pres, input logic fin);
    stim_t s;
    s.item.payload_byte   = b;
    s.item.byte_present   = pres;
    s.item.end_of_payload = fin;
    s.gap = $urandom_range(in_gap_max);
    byte_q.push_back(s);
  endtask

  // len payload bytes; the last may ride on the end marker; idle items mixed in
  task automatic send_dgram(input int unsigned len, input bit tail_on_end,
                            input int unsigned noise_pct);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) offer(8'($urandom), 1'b0, 1'b0);
      offer(8'($urandom), 1'b1, tail_on_end && (i == len - 1));
    end
    if (!tail_on_end || len == 0) offer(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] sa, input logic [31:0] da,
                          input logic [15:0] sp, input logic [15:0] dp);
    write_reg(RegSourceAddress, sa);
    write_reg(RegDestAddress, da);
    write_reg(RegSourcePort, {16'($urandom), sp});
    write_reg(RegDestPort, {16'($urandom), dp});
    // unmapped index must be ignored
    write_reg(CfgIdxW'($urandom_range(255, int'(RegDestPort) + 1)), $urandom);
  endtask

  // two-byte datagram whose words cancel the header sum: checksum goes out as ffff
  task automatic send_zero_sum(input logic [31:0] sa, input logic [31:0] da,
                               input logic [15:0] sp, input logic [15:0] dp);
    logic [15:0] w;
    w = ~header_sum(sa, da, sp, dp, UdpHdrLen + 16'd2);
    offer(w[15:8], 1'b1, 1'b0);
    offer(w[7:0], 1'b1, 1'b1);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || header_q.size() != 0) @(posedge clk);
    // idle items leave nothing to wait on; give the pipeline time to drain
    repeat (12) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned len;
    for (int unsigned d = 0; d < n; d++) begin
      in_gap_max = ($urandom_range(3) == 0) ? 0 : 9;
      case ($urandom_range(9))
        0:       len = $urandom_range(40, 21);
        1, 2, 3: len = $urandom_range(20, 7);
        default: len = $urandom_range(6);
      endcase
      send_dgram(len, $urandom_range(1), ($urandom_range(1) == 1) ? 15 : 0);
    end
  endtask

  initial begin
    logic [31:0] sa, da;
    logic [15:0] sp, dp;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset value
    in_gap_max = 2;
    out_gap_max <= 2;
    offer(8'h00, 1'b0, 1'b1);   // empty datagram
    offer(8'hff, 1'b0, 1'b0);   // idle
    offer(8'hff, 1'b1, 1'b0);
    offer(8'h5a, 1'b0, 1'b0);   // idle
    offer(8'h00, 1'b1, 1'b1);
    offer(8'hab, 1'b1, 1'b1);   // single odd byte
    offer(8'h01, 1'b1, 1'b0);
    offer(8'hfe, 1'b1, 1'b0);
    offer(8'h7f, 1'b1, 1'b1);
    offer(8'h12, 1'b1, 1'b0);
    offer(8'h34, 1'b1, 1'b0);
    offer(8'hc3, 1'b0, 1'b1);   // end marker, byte ignored
    wait_idle();

    sa = '1; da = '1; sp = '1; dp = '1;
    set_regs(sa, da, sp, dp);
    offer(8'hff, 1'b0, 1'b1);
    send_zero_sum(sa, da, sp, dp);
    offer(8'hff, 1'b1, 1'b0);
    offer(8'hff, 1'b1, 1'b0);
    offer(8'hff, 1'b1, 1'b1);
    wait_idle();

    sa = '0; da = '1; sp = '1; dp = '0;
    set_regs(sa, da, sp, dp);
    out_gap_max <= 9;
    send_zero_sum(sa, da, sp, dp);
    random_phase(5);
    wait_idle();

    sa = $urandom; da = $urandom; sp = 16'($urandom); dp = 16'($urandom);
    set_regs(sa, da, sp, dp);
    out_gap_max <= 0;
    random_phase(3);
    wait_idle();
    out_gap_max <= 9;
    random_phase(3);
    wait_idle();

    // receiver holds off while back-to-back datagrams pile up behind it
    in_gap_max = 0;
    out_gap_max <= 0;
    fork
      begin
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    for (int d = 0; d < 6; d++) send_dgram($urandom_range(3), $urandom_range(1), 0);
    wait_idle();

    sa = $urandom; da = $urandom; sp = 16'($urandom); dp = 16'($urandom);
    set_regs(sa, da, sp, dp);
    out_gap_max <= 9;
    send_zero_sum(sa, da, sp, dp);
    random_phase(6);

    for (int k = 0; k < 20000 && (byte_q.size() != 0 || in_valid || header_q.size() != 0); k++)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (header_q.size() != 0) begin
      $error("%0d expected header transfers never arrived", header_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
